### src/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Shared sizes, register indexes and sequencer states for the windowed mean
// with clamp.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int AXES       = 3;
  localparam int WINDOW_MAX = 64;
  localparam int DATA_W     = 32;
  localparam int SUM_W      = 38;
  localparam int WLEN_W     = 7;
  localparam int SAT_W      = 31;
  localparam int POS_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT  = CFG_IDX_W'(1);

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(30);
  localparam logic [SAT_W-1:0]  SAT_RESET  = SAT_W'(13107200);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ADD,
    ST_ABS,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

### src/wms_ram.sv
// ----------------------------------------------------------------------------
// wms_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module wms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/windowed_mean_saturate_top.sv
// ----------------------------------------------------------------------------
// windowed_mean_saturate_top
// Moving average over a ring of samples per axis, bit-serial divide by the
// fill count or window length, then a symmetric clamp.
// ----------------------------------------------------------------------------
// Sequence per beat: read the ring, add, take the magnitude, run the 38-step
// bit-serial divider, then clamp into the output register.
// Input stalls while an item is in flight; a finished result waits in the
// output register while the next beat is taken.
// Reset: window_len 30, sat_limit 200.0, ring valid bits, sums, index cleared.
module windowed_mean_saturate_top
  import wms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_W-1:0]     force_x_i,
  input  logic [DATA_W-1:0]     force_y_i,
  input  logic [DATA_W-1:0]     force_z_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_W-1:0]     mean_x_o,
  output logic [DATA_W-1:0]     mean_y_o,
  output logic [DATA_W-1:0]     mean_z_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [WLEN_W-1:0]     wlen_q;
  logic [SAT_W-1:0]      sat_q;
  logic [POS_W-1:0]      pos_q;
  logic                  wrapped_q;
  logic [WINDOW_MAX-1:0] ring_vld_q;
  logic [POS_W-1:0]      addr_q;
  logic [WLEN_W-1:0]     div_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  out_valid_q;

  logic signed [SUM_W-1:0] sum_q [AXES];
  logic [DATA_W-1:0]       smp_q [AXES];
  logic [SUM_W-1:0]        dvd_q [AXES];
  logic [WLEN_W-1:0]       rem_q [AXES];
  logic                    neg_q [AXES];
  logic [DATA_W-1:0]       mean_q [AXES];

  logic [DATA_W-1:0] force_in [AXES];
  logic [AXES*DATA_W-1:0] ram_wdata, ram_rdata;
  logic ram_we;

  logic in_acc, out_free, cfg_wr;
  logic [POS_W-1:0]  pos_cur;
  logic [WLEN_W-1:0] pos_nxt;
  logic              wrap_nxt;
  logic [WLEN_W-1:0] wlen_new;

  assign force_in[0] = force_x_i;
  assign force_in[1] = force_y_i;
  assign force_in[2] = force_z_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    pos_cur  = ({1'b0, pos_q} >= wlen_q) ? '0 : pos_q;
    pos_nxt  = WLEN_W'(pos_cur) + WLEN_W'(1);
    wrap_nxt = (pos_nxt >= wlen_q);
    wlen_new = cfg_data_i[WLEN_W-1:0];
    if (wlen_new == '0) begin
      wlen_new = WLEN_W'(1);
    end else if (wlen_new > WLEN_W'(WINDOW_MAX)) begin
      wlen_new = WLEN_W'(WINDOW_MAX);
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ram_wdata[a*DATA_W +: DATA_W] = smp_q[a];
    end
  end

  assign ram_we = (state_q == ST_ADD);

  wms_ram #(
    .WIDTH(AXES*DATA_W),
    .DEPTH(WINDOW_MAX)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(ram_wdata),
    .raddr_i(pos_cur),
    .rdata_o(ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_READ;
      ST_READ: state_d = ST_ADD;
      ST_ADD:  state_d = ST_ABS;
      ST_ABS:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == CNT_W'(SUM_W-1)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q      <= WLEN_RESET;
      sat_q       <= SAT_RESET;
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      ring_vld_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
      end
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pos_q <= wrap_nxt ? '0 : pos_nxt[POS_W-1:0];
            if (wrap_nxt) begin
              wrapped_q <= 1'b1;
            end
          end
        end
        ST_READ: begin
          for (int a = 0; a < AXES; a++) begin
            if (ring_vld_q[addr_q]) begin
              sum_q[a] <= sum_q[a] - SUM_W'($signed(ram_rdata[a*DATA_W +: DATA_W]));
            end
          end
        end
        ST_ADD: begin
          ring_vld_q[addr_q] <= 1'b1;
          for (int a = 0; a < AXES; a++) begin
            sum_q[a] <= sum_q[a] + SUM_W'($signed(smp_q[a]));
          end
        end
        ST_ABS:  cnt_q <= '0;
        ST_DIV:  cnt_q <= cnt_q + CNT_W'(1);
        default: ;
      endcase
      if (cfg_wr && cfg_index_i == REG_WINDOW_LEN) begin
        wlen_q     <= wlen_new;
        pos_q      <= '0;
        wrapped_q  <= 1'b0;
        ring_vld_q <= '0;
        for (int a = 0; a < AXES; a++) begin
          sum_q[a] <= '0;
        end
      end else if (cfg_wr && cfg_index_i == REG_SAT_LIMIT) begin
        sat_q <= cfg_data_i[SAT_W-1:0];
      end
    end
  end

  // datapath: sample capture, magnitude, bit-serial divide, clamp
  logic [WLEN_W:0]   trial [AXES];
  logic [WLEN_W:0]   diff  [AXES];
  logic              ge    [AXES];
  logic [SAT_W-1:0]  mag   [AXES];
  logic [DATA_W-1:0] res   [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      trial[a] = {rem_q[a], dvd_q[a][SUM_W-1]};
      diff[a]  = trial[a] - {1'b0, div_q};
      ge[a]    = (trial[a] >= {1'b0, div_q});
      mag[a]   = (dvd_q[a] > SUM_W'(sat_q)) ? sat_q : dvd_q[a][SAT_W-1:0];
      res[a]   = neg_q[a] ? (~{1'b0, mag[a]} + DATA_W'(1)) : {1'b0, mag[a]};
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          addr_q <= pos_cur;
          div_q  <= (wrap_nxt || wrapped_q) ? wlen_q : pos_nxt;
          for (int a = 0; a < AXES; a++) begin
            smp_q[a] <= force_in[a];
          end
        end
      end
      ST_ABS: begin
        for (int a = 0; a < AXES; a++) begin
          neg_q[a] <= sum_q[a][SUM_W-1];
          dvd_q[a] <= sum_q[a][SUM_W-1] ? SUM_W'(-sum_q[a]) : SUM_W'(sum_q[a]);
          rem_q[a] <= '0;
        end
      end
      ST_DIV: begin
        for (int a = 0; a < AXES; a++) begin
          rem_q[a] <= ge[a] ? diff[a][WLEN_W-1:0] : trial[a][WLEN_W-1:0];
          dvd_q[a] <= {dvd_q[a][SUM_W-2:0], ge[a]};
        end
      end
      ST_DONE: begin
        if (out_free) begin
          for (int a = 0; a < AXES; a++) begin
            mean_q[a] <= res[a];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign mean_x_o    = mean_q[0];
  assign mean_y_o    = mean_q[1];
  assign mean_z_o    = mean_q[2];

endmodule
